/* src/pwm_period_prescaler_calc_core_macros.svh */
// Assertion macros for the PWM period and prescaler core.
// Each expects signals named clk and rst_n in the scope of use.
`ifndef PWM_PERIOD_PRESCALER_CALC_CORE_MACROS_SVH
`define PWM_PERIOD_PRESCALER_CALC_CORE_MACROS_SVH

// Same-cycle implication
`define PPC_ASSERT_IMP(label, ant, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("ppc check failed");

// Next-cycle implication
`define PPC_ASSERT_NXT(label, ant, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("ppc check failed");

`endif

/* src/ppc_pkg.sv */
// ----------------------------------------------------------------------------
// ppc_pkg
// Widths, constants and item structs shared by the PWM period core.
// ----------------------------------------------------------------------------
package ppc_pkg;

    localparam int CLK_W   = 29;
    localparam int FREQ_W  = 27;
    localparam int PER_W   = 16;
    localparam int PSC_W   = 3;
    localparam int PSCX_W  = 5;
    localparam int TICK_SH = 5;               // times 32
    localparam int RAW_W   = CLK_W + TICK_SH; // 34-bit raw period / frequency

    localparam logic [CLK_W-1:0]  CLK_RESET = 29'd144000000;
    localparam logic [PSCX_W-1:0] TOP_BIT   = 5'd15;
    localparam logic [PER_W-1:0]  MIN_BASE  = 16'd96;
    localparam logic [PER_W-1:0]  MIN_FLOOR = 16'h0003;
    localparam logic [PER_W-1:0]  MAX_BASE  = 16'hFFFF;
    localparam logic [PER_W-1:0]  MAX_FLOOR = 16'hFFFD;
    localparam logic [PER_W-1:0]  TICK_MULT = 16'd32;
    localparam logic [PSCX_W-1:0] PSC_MAX   = 5'd7;

    // Register map
    localparam logic [2:0] REG_TIMER_CLK = 3'd0;

    // Sideband through the period divider
    typedef struct packed {
        logic [CLK_W-1:0] clk_hz;
        logic             zero;
    } ppc_side_t;

    // Sideband through the frequency divider
    typedef struct packed {
        logic [CLK_W-1:0]  clk_hz;
        logic [PER_W-1:0]  period;
        logic [PSCX_W-1:0] psc;
        logic              bad;
        logic              zero;
    } ppc_info_t;

endpackage

/* src/ppc_div.sv */
// ----------------------------------------------------------------------------
// ppc_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module ppc_div #(
    parameter int NUM_W  = 34,
    parameter int DEN_W  = 27,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [NUM_W-1:0]  out_quo,
    output logic [SIDE_W-1:0] out_side
);

    logic              vld_a  [0:NUM_W];
    logic [NUM_W-1:0]  num_a  [0:NUM_W];
    logic [NUM_W-1:0]  quo_a  [0:NUM_W];
    logic [DEN_W-1:0]  rem_a  [0:NUM_W];
    logic [DEN_W-1:0]  den_a  [0:NUM_W];
    logic [SIDE_W-1:0] side_a [0:NUM_W];

    // stage 0 is the input itself
    assign vld_a[0]  = in_valid;
    assign num_a[0]  = in_num;
    assign quo_a[0]  = '0;
    assign rem_a[0]  = '0;
    assign den_a[0]  = in_den;
    assign side_a[0] = in_side;

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W-1:0] rem_next;
        logic [DEN_W:0]   diff;

        // one trial subtraction
        always_comb
        begin
            trial    = {rem_a[s], num_a[s][NUM_W-1]};
            diff     = trial - {1'b0, den_a[s]};
            ge       = (trial >= {1'b0, den_a[s]});
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_a[s+1] <= 1'b0;
            end
            else if (adv)
            begin
                vld_a[s+1] <= vld_a[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                num_a[s+1]  <= {num_a[s][NUM_W-2:0], 1'b0};
                quo_a[s+1]  <= {quo_a[s][NUM_W-2:0], ge};
                rem_a[s+1]  <= rem_next;
                den_a[s+1]  <= den_a[s];
                side_a[s+1] <= side_a[s];
            end
        end
    end

    assign out_valid = vld_a[NUM_W];
    assign out_quo   = quo_a[NUM_W];
    assign out_side  = side_a[NUM_W];

endmodule

/* src/ppc_psc.sv */
// ----------------------------------------------------------------------------
// ppc_psc
// Prescaler selection: top-bit search and shift, then limit check and step.
// ----------------------------------------------------------------------------
module ppc_psc (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      in_valid,
    input  logic [ppc_pkg::RAW_W-1:0] raw,
    input  ppc_pkg::ppc_side_t        side,
    output logic                      out_valid,
    output ppc_pkg::ppc_info_t        info
);
    import ppc_pkg::*;

    logic [5:0]        msb;
    logic [PSCX_W-1:0] psc0;
    logic [RAW_W-1:0]  shifted;

    logic              v1_reg;
    logic [PER_W-1:0]  per1_reg;
    logic [PSCX_W-1:0] psc1_reg;
    logic [CLK_W-1:0]  clk1_reg;
    logic              zero1_reg;

    logic [PER_W-1:0]  min_p;
    logic [PER_W-1:0]  max_p;
    logic              over;
    logic [PSCX_W-1:0] psc_f;
    logic [PER_W-1:0]  per_f;
    logic              bad;

    logic              v2_reg;
    ppc_info_t         info_reg;

    // top set bit and first shift
    always_comb
    begin
        msb = '0;
        for (int i = 0; i < RAW_W; i++)
        begin
            if (raw[i])
            begin
                msb = 6'(i);
            end
        end
        psc0    = (msb > 6'(TOP_BIT)) ? 5'(msb - 6'(TOP_BIT)) : '0;
        shifted = raw >> psc0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            per1_reg  <= shifted[PER_W-1:0];
            psc1_reg  <= psc0;
            clk1_reg  <= side.clk_hz;
            zero1_reg <= side.zero;
        end
    end

    // limits, one more halving if needed, range flag
    always_comb
    begin
        min_p = (psc1_reg < 5'd5) ? (MIN_BASE >> psc1_reg) : MIN_FLOOR;
        max_p = (psc1_reg < 5'd4) ? (MAX_BASE - (TICK_MULT >> psc1_reg)) : MAX_FLOOR;
        over  = (per1_reg > max_p);
        psc_f = over ? (psc1_reg + 5'd1) : psc1_reg;
        per_f = over ? (per1_reg >> 1) : per1_reg;
        bad   = zero1_reg || (psc_f > PSC_MAX) || (per_f < min_p) || (per_f > max_p);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            info_reg.clk_hz <= clk1_reg;
            info_reg.period <= per_f;
            info_reg.psc    <= psc_f;
            info_reg.bad    <= bad;
            info_reg.zero   <= zero1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign info      = info_reg;

endmodule

/* src/pwm_period_prescaler_calc_core.sv */
// ----------------------------------------------------------------------------
// pwm_period_prescaler_calc_core
// PWM period, prescaler and obtained frequency from a requested frequency.
// ----------------------------------------------------------------------------
//  channel   signals                                     direction
//  request   req_valid, req_stall, requested_freq_hz     in
//  result    res_valid, res_stall, period_count,
//            prescaler, effective_freq_hz, out_of_range  out
//  config    APB: psel, penable, pwrite, paddr, ...      in/out
//
// One item per cycle unless a result is held by res_stall; 34 stages of the period divider,
// 2 prescaler stages, 34 stages of the frequency divider, 1 output register.
// The whole pipeline advances unless a result is held by res_stall.
// Reset clears valid bits and loads the timer clock with 144 MHz.
module pwm_period_prescaler_calc_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  logic [ppc_pkg::FREQ_W-1:0] requested_freq_hz,
    output logic                       res_valid,
    input  logic                       res_stall,
    output logic [ppc_pkg::PER_W-1:0]  period_count,
    output logic [ppc_pkg::PSC_W-1:0]  prescaler,
    output logic [ppc_pkg::CLK_W-1:0]  effective_freq_hz,
    output logic                       out_of_range
);
    import ppc_pkg::*;

    logic [CLK_W-1:0] clk_hz_reg;
    logic             adv;

    ppc_side_t        side1;
    logic             d1_valid;
    logic [RAW_W-1:0] d1_quo;
    logic [$bits(ppc_side_t)-1:0] d1_side;

    logic             p_valid;
    ppc_info_t        p_info;

    logic             d2_valid;
    logic [RAW_W-1:0] d2_quo;
    logic [$bits(ppc_info_t)-1:0] d2_side;
    ppc_info_t        info2;
    logic [RAW_W-1:0] eff_sh;

    logic             res_valid_reg;
    logic [PER_W-1:0] period_reg;
    logic [PSC_W-1:0] psc_reg;
    logic [CLK_W-1:0] eff_reg;
    logic             oor_reg;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr == REG_TIMER_CLK) ? {3'b000, clk_hz_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_hz_reg <= CLK_RESET;
        end
        else if (psel && penable && pwrite && (paddr == REG_TIMER_CLK))
        begin
            clk_hz_reg <= pwdata[CLK_W-1:0];
        end
    end

    // global advance
    assign adv       = !res_valid_reg || !res_stall;
    assign req_stall = !adv;

    // raw period = clk*32 / freq
    assign side1.clk_hz = clk_hz_reg;
    assign side1.zero   = (requested_freq_hz == '0);

    ppc_div #(
        .NUM_W  (RAW_W),
        .DEN_W  (FREQ_W),
        .SIDE_W ($bits(ppc_side_t))
    ) u_div_period (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (req_valid),
        .in_num    ({clk_hz_reg, 5'b00000}),
        .in_den    (requested_freq_hz),
        .in_side   (side1),
        .out_valid (d1_valid),
        .out_quo   (d1_quo),
        .out_side  (d1_side)
    );

    ppc_psc u_psc (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (d1_valid),
        .raw       (d1_quo),
        .side      (ppc_side_t'(d1_side)),
        .out_valid (p_valid),
        .info      (p_info)
    );

    // obtained frequency = clk*32 / period
    ppc_div #(
        .NUM_W  (RAW_W),
        .DEN_W  (PER_W),
        .SIDE_W ($bits(ppc_info_t))
    ) u_div_freq (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (p_valid),
        .in_num    ({p_info.clk_hz, 5'b00000}),
        .in_den    (p_info.period),
        .in_side   (p_info),
        .out_valid (d2_valid),
        .out_quo   (d2_quo),
        .out_side  (d2_side)
    );

    assign info2  = ppc_info_t'(d2_side);
    assign eff_sh = d2_quo >> info2.psc[PSC_W-1:0];

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            res_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            period_reg <= info2.bad ? '0 : info2.period;
            if (info2.zero)
            begin
                psc_reg <= '0;
            end
            else if (info2.psc > PSC_MAX)
            begin
                psc_reg <= PSC_MAX[PSC_W-1:0];
            end
            else
            begin
                psc_reg <= info2.psc[PSC_W-1:0];
            end
            eff_reg <= info2.bad ? '0 : eff_sh[CLK_W-1:0];
            oor_reg <= info2.bad;
        end
    end

    assign res_valid         = res_valid_reg;
    assign period_count      = period_reg;
    assign prescaler         = psc_reg;
    assign effective_freq_hz = eff_reg;
    assign out_of_range      = oor_reg;

endmodule

/* src/ppc_checker.sv */
// ----------------------------------------------------------------------------
// ppc_checker
// Port-level checks on the PWM period core, bound to the top level.
// ----------------------------------------------------------------------------
`include "pwm_period_prescaler_calc_core_macros.svh"

module ppc_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_stall,
    input logic                       res_valid,
    input logic                       res_stall,
    input logic [ppc_pkg::PER_W-1:0]  period_count,
    input logic [ppc_pkg::PSC_W-1:0]  prescaler,
    input logic [ppc_pkg::CLK_W-1:0]  effective_freq_hz,
    input logic                       out_of_range
);
    import ppc_pkg::*;

    // flagged results carry zero period and frequency
    `PPC_ASSERT_IMP(a_oor_zero, res_valid && out_of_range, (period_count == '0) && (effective_freq_hz == '0))

    // an in-range period is never below the floor
    `PPC_ASSERT_IMP(a_per_min, res_valid && !out_of_range, period_count >= MIN_FLOOR)

    // without prescaling the period keeps its top margin
    `PPC_ASSERT_IMP(a_per_max0, res_valid && !out_of_range && (prescaler == '0), period_count <= (MAX_BASE - TICK_MULT))

    // a held result stays put
    `PPC_ASSERT_NXT(a_hold, res_valid && res_stall, res_valid && $stable(period_count) && $stable(effective_freq_hz))

    // input stalls only while a result is held
    `PPC_ASSERT_IMP(a_stall_src, req_stall, res_valid && res_stall)

endmodule

bind pwm_period_prescaler_calc_core ppc_checker u_ppc_checker (.*);

/* dv/pwm_period_prescaler_calc_core_test.sv */
// ----------------------------------------------------------------------------
// pwm_period_prescaler_calc_core_test
// Drives frequency requests at the PWM period core, predicts period,
// prescaler, obtained frequency and range flag for each accepted item, and
// checks results in order. The timer clock is reprogrammed between phases.
// ----------------------------------------------------------------------------
module pwm_period_prescaler_calc_core_test;
    import ppc_pkg::*;

    localparam int LATENCY = 71;

    typedef struct packed {
        logic [PER_W-1:0] period;
        logic [PSC_W-1:0] psc;
        logic [CLK_W-1:0] eff;
        logic             oor;
    } period_res_t;

    logic              clk;
    logic              rst_n;
    logic              psel, penable, pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata, prdata;
    logic              pready;
    logic              req_valid, req_stall;
    logic [FREQ_W-1:0] requested_freq_hz;
    logic              res_valid, res_stall;
    logic [PER_W-1:0]  period_count;
    logic [PSC_W-1:0]  prescaler;
    logic [CLK_W-1:0]  effective_freq_hz;
    logic              out_of_range;

    logic [FREQ_W-1:0] pending_freqs[$];
    period_res_t       expected_periods[$];
    logic [CLK_W-1:0]  timer_clk_hz;
    int                errors = 0;
    bit                src_busy_free;   // sender stops idling
    bit                snk_busy_free;   // receiver stops idling
    int                hold_len;        // requested receiver hold-off
    int                hold_cycles;     // hold-off cycles still to run
    bit                hold_taken;      // hold-off already started

    // Directed items: field extremes, zero frequency, tiny and huge periods
    logic [FREQ_W-1:0] first_freqs [18] = '{
        27'd0, 27'd1, 27'd2, 27'd3, 27'd100, 27'd1000, 27'd2197, 27'd2198,
        27'd20000, 27'd65535, 27'd1000000, 27'd1500000, 27'd20000000,
        27'd48000000, 27'd100000000, 27'h7FFFFFF, 27'h5555555, 27'h2AAAAAA};
    // Low frequencies against the largest clock
    logic [FREQ_W-1:0] wide_clk_freqs [5] = '{
        27'd0, 27'd1, 27'd7, 27'd100, 27'h7FFFFFF};

    pwm_period_prescaler_calc_core dut (.*);

    always #2 clk = ~clk;

    // Period, prescaler and obtained frequency for one request
    function automatic period_res_t calc_period(logic [CLK_W-1:0] clk_hz,
                                                logic [FREQ_W-1:0] freq);
        period_res_t r;
        logic [63:0] c, f, per, min_p, max_p, e;
        int          msb, psc;
        bit          bad;
        r = '0;
        c = 64'(clk_hz);
        f = 64'(freq);
        if (f == 0)
        begin
            r.oor = 1'b1;
            return r;
        end
        per = (c / f) * 32 + ((c % f) * 32) / f;
        msb = 0;
        for (int i = 0; i < 64; i++)
            if (per[i])
                msb = i;
        psc = (msb > 15) ? msb - 15 : 0;
        per = per >> psc;
        min_p = (psc < 5) ? (64'd96 >> psc) : 64'd3;
        max_p = (psc < 4) ? (64'hFFFF - (64'd32 >> psc)) : 64'hFFFD;
        if (per > max_p)
        begin
            psc++;
            per = per >> 1;
        end
        bad = (psc > 7) || (per < min_p) || (per > max_p);
        e = 0;
        if (!bad)
            e = ((c / per) * 32 + ((c % per) * 32) / per) >> psc;
        r.period = bad ? '0 : per[PER_W-1:0];
        r.psc    = (psc > 7) ? 3'd7 : psc[PSC_W-1:0];
        r.eff    = bad ? '0 : e[CLK_W-1:0];
        r.oor    = bad;
        return r;
    endfunction

    // Driver: offers pending items, idles at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid         <= 1'b0;
            requested_freq_hz <= '0;
        end
        else if (!req_valid || !req_stall)
        begin
            if (req_valid)
                expected_periods.push_back(calc_period(timer_clk_hz, requested_freq_hz));
            if (pending_freqs.size() > 0 &&
                (src_busy_free || $urandom_range(99) >= 17))
            begin
                req_valid         <= 1'b1;
                requested_freq_hz <= pending_freqs.pop_front();
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Receiver stall: random, or held for a long stretch
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall   <= 1'b0;
            hold_cycles <= 0;
            hold_taken  <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            res_stall   <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else if (!hold_taken && hold_len > 0)
        begin
            res_stall   <= 1'b1;
            hold_cycles <= hold_len - 1;
            hold_taken  <= 1'b1;
        end
        else
            res_stall <= !snk_busy_free && ($urandom_range(99) < 17);
    end

    // Monitor: compares each result with the oldest expectation
    always @(posedge clk)
    begin
        period_res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_periods.size() == 0)
            begin
                $error("unexpected result");
                errors++;
            end
            else
            begin
                want = expected_periods.pop_front();
                if (period_count !== want.period)
                begin
                    $error("period_count exp %0d got %0d", want.period, period_count);
                    errors++;
                end
                if (prescaler !== want.psc)
                begin
                    $error("prescaler exp %0d got %0d", want.psc, prescaler);
                    errors++;
                end
                if (effective_freq_hz !== want.eff)
                begin
                    $error("effective_freq_hz exp %0d got %0d", want.eff,
                           effective_freq_hz);
                    errors++;
                end
                if (out_of_range !== want.oor)
                begin
                    $error("out_of_range exp %0d got %0d", want.oor, out_of_range);
                    errors++;
                end
            end
        end
    end

    task automatic write_timer_clk(logic [CLK_W-1:0] hz);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= REG_TIMER_CLK;
        pwdata  <= 32'(hz);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        timer_clk_hz = hz;
    endtask

    task automatic drain;
        while (pending_freqs.size() > 0 || req_valid || expected_periods.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    // Random frequency with a spread of magnitudes
    function automatic logic [FREQ_W-1:0] rand_freq();
        int sh;
        sh = $urandom_range(26, 0);
        case ($urandom_range(9))
            0: return FREQ_W'($urandom_range(100000000, 1));
            1: return FREQ_W'($urandom);
            2: return '0;
            default: return FREQ_W'($urandom) >> sh;
        endcase
    endfunction

    task automatic random_phase(int n);
        repeat (n) pending_freqs.push_back(rand_freq());
    endtask

    initial
    begin
        clk = 0; rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        timer_clk_hz = CLK_RESET;
        src_busy_free = 0; snk_busy_free = 0; hold_len = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, zero frequency, tiny and huge periods
        foreach (first_freqs[i])
            pending_freqs.push_back(first_freqs[i]);
        random_phase(120);
        drain();

        // Largest clock: prescaler beyond seven with low frequencies
        write_timer_clk(29'h1FFFFFFF);
        foreach (wide_clk_freqs[i])
            pending_freqs.push_back(wide_clk_freqs[i]);
        random_phase(100);
        // Long receiver hold-off while sender runs flat out
        src_busy_free = 1;
        @(posedge clk);
        hold_len = 150;
        drain();
        src_busy_free = 0;

        write_timer_clk(29'd1000000);
        random_phase(100);
        drain();

        // No idling on either side
        write_timer_clk(29'd400000000);
        src_busy_free = 1; snk_busy_free = 1;
        random_phase(100);
        drain();
        src_busy_free = 0; snk_busy_free = 0;

        write_timer_clk(29'($urandom_range(400000000, 1000000)));
        random_phase(100);
        drain();

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #400000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/ppc_pkg.sv
src/ppc_div.sv
src/ppc_psc.sv
src/pwm_period_prescaler_calc_core.sv
src/ppc_checker.sv
dv/pwm_period_prescaler_calc_core_test.sv
